>>> design/ssc_pkg.sv
package ssc_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int TMP_DEPTH         = 32;
    localparam int TMP_AW            = $clog2(TMP_DEPTH);

    typedef logic [6:0] pc_t;
    typedef logic [5:0] src_t;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_ABS,
        OP_X10,
        OP_MUL,
        OP_AVG,
        OP_SELN,
        OP_DIV,
        OP_BNOPP,
        OP_BNALIKE,
        OP_BNPOS,
        OP_BNTRAJ,
        OP_DONE,
        OP_DONEP
    } op_t;

    typedef enum logic [2:0] {
        CFG_MODE,
        CFG_LENGTH,
        CFG_PERIOD,
        CFG_STEP,
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_HEADING
    } cfg_idx_t;

    localparam logic [1:0] MODE_TRAJ = 2'd1;
    localparam logic [1:0] MODE_POS  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OPER,
        ST_DIVW,
        ST_EMIT
    } state_t;

    localparam src_t SRC_ZERO   = 6'd0;
    localparam src_t SRC_ONE    = 6'd1;
    localparam src_t SRC_HUND   = 6'd2;
    localparam src_t SRC_TENTH  = 6'd3;
    localparam src_t SRC_PX     = 6'd4;
    localparam src_t SRC_PY     = 6'd5;
    localparam src_t SRC_HD     = 6'd6;
    localparam src_t SRC_VX     = 6'd7;
    localparam src_t SRC_VY     = 6'd8;
    localparam src_t SRC_WZ     = 6'd9;
    localparam src_t SRC_FX     = 6'd10;
    localparam src_t SRC_FY     = 6'd11;
    localparam src_t SRC_NOW    = 6'd12;
    localparam src_t SRC_OX     = 6'd13;
    localparam src_t SRC_OY     = 6'd14;
    localparam src_t SRC_OH     = 6'd15;
    localparam src_t SRC_LEN    = 6'd16;
    localparam src_t SRC_PER    = 6'd17;
    localparam src_t SRC_DT     = 6'd18;
    localparam src_t SRC_PREV   = 6'd19;
    localparam src_t SRC_AVH    = 6'd20;
    localparam src_t SRC_AVY    = 6'd21;
    localparam src_t SRC_AVW    = 6'd22;
    localparam src_t SRC_HCUR   = 6'd23;
    localparam src_t SRC_HRATE  = 6'd24;
    localparam src_t SRC_LCT    = 6'd25;
    localparam src_t SRC_SSTART = 6'd26;
    localparam src_t SRC_SPHASE = 6'd27;
    localparam src_t SRC_CPER   = 6'd28;
    localparam src_t SRC_CPRATE = 6'd29;
    localparam src_t SRC_TMP    = 6'd32;

    localparam pc_t L_THIRD_A = 7'd55;
    localparam pc_t L_THIRD_B = 7'd62;
    localparam pc_t L_POS_END = 7'd69;
    localparam pc_t L_TRAJ    = 7'd81;
    localparam pc_t L_BLEND   = 7'd91;
    localparam pc_t L_END     = 7'd95;

    typedef struct packed {
        op_t  op;
        src_t dst;
        src_t a;
        src_t b;
        pc_t  tgt;
    } instr_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] value;
    } alu_res_t;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [31:0] value;
    } div_res_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] yaw_rate;
        logic signed [31:0] flow_x;
        logic signed [31:0] flow_y;
        logic signed [31:0] step_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] curvature_offset;
        logic signed [31:0] curvature_rate;
        logic signed [31:0] period_value;
        logic signed [31:0] period_rate;
        logic signed [31:0] phase_origin;
        logic signed [31:0] phase_shift;
        logic               period_active;
        logic               saturated;
    } out_item_t;

    function automatic src_t tmp(input int k);
        return SRC_TMP | src_t'(k);
    endfunction

    function automatic instr_t mk(input op_t op, input src_t dst, input src_t a,
                                  input src_t b, input pc_t tgt);
        instr_t i;
        i.op  = op;
        i.dst = dst;
        i.a   = a;
        i.b   = b;
        i.tgt = tgt;
        return i;
    endfunction

    function automatic instr_t prog(input pc_t pc);
        instr_t i;
        unique case (pc)
            7'd0:  i = mk(OP_DIV, tmp(0), SRC_DT, SRC_PER, '0);
            7'd1:  i = mk(OP_SUB, tmp(1), SRC_PX, SRC_OX, '0);
            7'd2:  i = mk(OP_DIV, tmp(1), tmp(1), SRC_LEN, '0);
            7'd3:  i = mk(OP_SUB, tmp(2), SRC_PY, SRC_OY, '0);
            7'd4:  i = mk(OP_DIV, tmp(2), tmp(2), SRC_LEN, '0);
            7'd5:  i = mk(OP_SUB, tmp(3), SRC_HD, SRC_OH, '0);
            7'd6:  i = mk(OP_ADD, tmp(4), SRC_VX, SRC_FX, '0);
            7'd7:  i = mk(OP_DIV, tmp(4), tmp(4), SRC_LEN, '0);
            7'd8:  i = mk(OP_ADD, tmp(5), SRC_VY, SRC_FY, '0);
            7'd9:  i = mk(OP_DIV, tmp(5), tmp(5), SRC_LEN, '0);
            7'd10: i = mk(OP_AVG, tmp(6), SRC_WZ, SRC_PREV, '0);
            7'd11: i = mk(OP_MUL, tmp(6), tmp(6), SRC_PER, '0);
            7'd12: i = mk(OP_SUB, tmp(7), SRC_WZ, SRC_PREV, '0);
            7'd13: i = mk(OP_MUL, tmp(7), tmp(7), SRC_PER, '0);
            7'd14: i = mk(OP_DIV, tmp(7), tmp(7), SRC_DT, '0);
            7'd15: i = mk(OP_ADD, SRC_PREV, SRC_WZ, SRC_ZERO, '0);
            7'd16: i = mk(OP_SUB, tmp(8), tmp(3), SRC_AVH, '0);
            7'd17: i = mk(OP_DIV, tmp(8), tmp(8), SRC_PER, '0);
            7'd18: i = mk(OP_MUL, tmp(9), tmp(0), SRC_WZ, '0);
            7'd19: i = mk(OP_ADD, tmp(8), tmp(8), tmp(9), '0);
            7'd20: i = mk(OP_SUB, tmp(9), tmp(2), SRC_AVY, '0);
            7'd21: i = mk(OP_DIV, tmp(9), tmp(9), SRC_PER, '0);
            7'd22: i = mk(OP_MUL, tmp(10), tmp(0), tmp(5), '0);
            7'd23: i = mk(OP_ADD, tmp(9), tmp(9), tmp(10), '0);
            7'd24: i = mk(OP_SUB, tmp(10), tmp(6), SRC_AVW, '0);
            7'd25: i = mk(OP_DIV, tmp(10), tmp(10), SRC_PER, '0);
            7'd26: i = mk(OP_MUL, tmp(11), tmp(0), tmp(7), '0);
            7'd27: i = mk(OP_ADD, tmp(10), tmp(10), tmp(11), '0);
            7'd28: i = mk(OP_X10, tmp(10), tmp(10), SRC_ZERO, '0);
            7'd29: i = mk(OP_SUB, tmp(11), SRC_ONE, tmp(0), '0);
            7'd30: i = mk(OP_MUL, tmp(12), tmp(11), SRC_AVH, '0);
            7'd31: i = mk(OP_MUL, tmp(13), tmp(0), tmp(3), '0);
            7'd32: i = mk(OP_ADD, SRC_AVH, tmp(12), tmp(13), '0);
            7'd33: i = mk(OP_MUL, tmp(12), tmp(11), SRC_AVY, '0);
            7'd34: i = mk(OP_MUL, tmp(13), tmp(0), tmp(2), '0);
            7'd35: i = mk(OP_ADD, SRC_AVY, tmp(12), tmp(13), '0);
            7'd36: i = mk(OP_X10, tmp(11), tmp(0), SRC_ZERO, '0);
            7'd37: i = mk(OP_SUB, tmp(12), SRC_ONE, tmp(11), '0);
            7'd38: i = mk(OP_MUL, tmp(12), tmp(12), SRC_AVW, '0);
            7'd39: i = mk(OP_MUL, tmp(13), tmp(11), tmp(6), '0);
            7'd40: i = mk(OP_ADD, SRC_AVW, tmp(12), tmp(13), '0);
            7'd41: i = mk(OP_ABS, tmp(11), tmp(2), SRC_ZERO, '0);
            7'd42: i = mk(OP_ABS, tmp(12), SRC_AVY, SRC_ZERO, '0);
            7'd43: i = mk(OP_SELN, tmp(13), tmp(2), tmp(5), '0);
            7'd44: i = mk(OP_SELN, tmp(14), SRC_AVY, tmp(9), '0);
            7'd45: i = mk(OP_BNPOS, SRC_ZERO, SRC_ZERO, SRC_ZERO, L_TRAJ);
            7'd46: i = mk(OP_ADD, tmp(15), SRC_ZERO, SRC_ZERO, '0);
            7'd47: i = mk(OP_ADD, tmp(16), SRC_ZERO, SRC_ZERO, '0);
            7'd48: i = mk(OP_BNOPP, SRC_ZERO, SRC_AVH, tmp(2), L_THIRD_A);
            7'd49: i = mk(OP_MUL, tmp(17), SRC_AVH, tmp(11), '0);
            7'd50: i = mk(OP_ADD, tmp(15), tmp(15), tmp(17), '0);
            7'd51: i = mk(OP_MUL, tmp(17), tmp(13), SRC_AVH, '0);
            7'd52: i = mk(OP_MUL, tmp(18), tmp(11), tmp(8), '0);
            7'd53: i = mk(OP_ADD, tmp(17), tmp(17), tmp(18), '0);
            7'd54: i = mk(OP_ADD, tmp(16), tmp(16), tmp(17), '0);
            7'd55: i = mk(OP_BNOPP, SRC_ZERO, tmp(3), SRC_AVY, L_THIRD_B);
            7'd56: i = mk(OP_MUL, tmp(17), tmp(3), tmp(12), '0);
            7'd57: i = mk(OP_ADD, tmp(15), tmp(15), tmp(17), '0);
            7'd58: i = mk(OP_MUL, tmp(17), tmp(14), tmp(3), '0);
            7'd59: i = mk(OP_MUL, tmp(18), tmp(12), SRC_WZ, '0);
            7'd60: i = mk(OP_ADD, tmp(17), tmp(17), tmp(18), '0);
            7'd61: i = mk(OP_ADD, tmp(16), tmp(16), tmp(17), '0);
            7'd62: i = mk(OP_BNOPP, SRC_ZERO, SRC_AVH, SRC_AVY, L_POS_END);
            7'd63: i = mk(OP_MUL, tmp(17), SRC_AVH, tmp(12), '0);
            7'd64: i = mk(OP_ADD, tmp(15), tmp(15), tmp(17), '0);
            7'd65: i = mk(OP_MUL, tmp(17), tmp(14), SRC_AVH, '0);
            7'd66: i = mk(OP_MUL, tmp(18), tmp(12), tmp(8), '0);
            7'd67: i = mk(OP_ADD, tmp(17), tmp(17), tmp(18), '0);
            7'd68: i = mk(OP_ADD, tmp(16), tmp(16), tmp(17), '0);
            7'd69: i = mk(OP_ADD, SRC_HCUR, tmp(15), SRC_ZERO, '0);
            7'd70: i = mk(OP_ADD, SRC_HRATE, tmp(16), SRC_ZERO, '0);
            7'd71: i = mk(OP_SUB, tmp(17), SRC_LCT, SRC_SSTART, '0);
            7'd72: i = mk(OP_DIV, tmp(17), tmp(17), SRC_CPER, '0);
            7'd73: i = mk(OP_ADD, SRC_SPHASE, tmp(17), SRC_SPHASE, '0);
            7'd74: i = mk(OP_ADD, SRC_SSTART, SRC_LCT, SRC_ZERO, '0);
            7'd75: i = mk(OP_SUB, tmp(17), SRC_ONE, tmp(1), '0);
            7'd76: i = mk(OP_MUL, SRC_CPER, SRC_PER, tmp(17), '0);
            7'd77: i = mk(OP_NEG, tmp(17), tmp(4), SRC_ZERO, '0);
            7'd78: i = mk(OP_MUL, SRC_CPRATE, SRC_PER, tmp(17), '0);
            7'd79: i = mk(OP_ADD, SRC_LCT, SRC_NOW, SRC_ZERO, '0);
            7'd80: i = mk(OP_DONEP, SRC_ZERO, SRC_ZERO, SRC_ZERO, '0);
            7'd81: i = mk(OP_BNTRAJ, SRC_ZERO, SRC_ZERO, SRC_ZERO, L_END);
            7'd82: i = mk(OP_ABS, tmp(15), SRC_AVW, SRC_ZERO, '0);
            7'd83: i = mk(OP_SELN, tmp(16), SRC_AVW, tmp(10), '0);
            7'd84: i = mk(OP_MUL, tmp(17), tmp(3), tmp(15), '0);
            7'd85: i = mk(OP_MUL, tmp(18), tmp(3), tmp(16), '0);
            7'd86: i = mk(OP_MUL, tmp(19), SRC_WZ, tmp(15), '0);
            7'd87: i = mk(OP_ADD, tmp(18), tmp(18), tmp(19), '0);
            7'd88: i = mk(OP_BNALIKE, SRC_ZERO, tmp(3), SRC_AVW, L_BLEND);
            7'd89: i = mk(OP_MUL, tmp(17), SRC_HUND, tmp(17), '0);
            7'd90: i = mk(OP_MUL, tmp(18), SRC_HUND, tmp(18), '0);
            7'd91: i = mk(OP_MUL, tmp(19), SRC_TENTH, SRC_AVH, '0);
            7'd92: i = mk(OP_ADD, SRC_HCUR, tmp(17), tmp(19), '0);
            7'd93: i = mk(OP_MUL, tmp(19), SRC_TENTH, tmp(8), '0);
            7'd94: i = mk(OP_ADD, SRC_HRATE, tmp(18), tmp(19), '0);
            default: i = mk(OP_DONE, SRC_ZERO, SRC_ZERO, SRC_ZERO, '0);
        endcase
        return i;
    endfunction

endpackage

>>> design/ssc_item_if.sv
interface ssc_item_if import ssc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ssc_result_if.sv
interface ssc_result_if import ssc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ssc_alu.sv
module ssc_alu import ssc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  op_t                op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output alu_res_t           res
);

    logic signed [63:0] prod;
    logic signed [65:0] sum;

    function automatic alu_res_t clip(input logic signed [65:0] v);
        alu_res_t r;
        if (v > 66'sd2147483647)
        begin
            r.sat   = 1'b1;
            r.value = 32'sh7fff_ffff;
        end
        else if (v < -66'sd2147483648)
        begin
            r.sat   = 1'b1;
            r.value = 32'sh8000_0000;
        end
        else
        begin
            r.sat   = 1'b0;
            r.value = v[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        prod = a * b;
        sum  = 66'(a) + 66'(b);
        case (op)
            OP_ADD:  res = clip(sum);
            OP_SUB:  res = clip(66'(a) - 66'(b));
            OP_NEG:  res = clip(-66'(a));
            OP_ABS:  res = (a < 0) ? clip(-66'(a)) : '{sat: 1'b0, value: a};
            OP_X10:  res = clip(66'(a) * 66'sd10);
            OP_MUL:  res = clip(66'(prod >>> FRAC_BITS));
            OP_AVG:  res = '{sat: 1'b0, value: 32'(sum >>> 1)};
            OP_SELN: res = (a > 0) ? '{sat: 1'b0, value: b} : clip(-66'(b));
            default: res = '{sat: 1'b0, value: 32'sd0};
        endcase
    end

endmodule

>>> design/ssc_div.sv
module ssc_div import ssc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]      dvd_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [CW-1:0]      cnt_reg;
    logic               zero_reg;
    logic signed [31:0] zval_reg;
    logic               done_reg;

    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] shifted;
    logic        ge;

    assign num_mag = req.num[31] ? 32'(-req.num) : 32'(req.num);
    assign den_mag = req.den[31] ? 32'(-req.den) : 32'(req.den);
    assign shifted = {rem_reg[31:0], dvd_reg[DW-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.den == 32'sd0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= CW'(DW);
                end
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            zero_reg <= (req.den == 32'sd0);
            zval_reg <= (req.num > 0) ? 32'sh7fff_ffff :
                        ((req.num < 0) ? 32'sh8000_0000 : 32'sd0);
            dvd_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            den_reg  <= den_mag;
            neg_reg  <= req.num[31] ^ req.den[31];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
            dvd_reg <= {dvd_reg[DW-2:0], ge};
        end
    end

    always_comb
    begin
        res.done = done_reg;
        if (zero_reg)
        begin
            res.sat   = 1'b1;
            res.value = zval_reg;
        end
        else if (neg_reg)
        begin
            res.sat   = dvd_reg > DW'(64'h8000_0000);
            res.value = res.sat ? 32'sh8000_0000 : -$signed(dvd_reg[31:0]);
        end
        else
        begin
            res.sat   = dvd_reg > DW'(64'h7fff_ffff);
            res.value = res.sat ? 32'sh7fff_ffff : $signed(dvd_reg[31:0]);
        end
    end

endmodule

>>> design/swimmer_steering_controller.sv
// Steering controller for a swimmer, one item per simulation step. A small
// microprogram runs each step through one shared add/multiply/saturate unit
// and a radix-2 divider, keeping its scratch values in a 32-entry register
// memory. A plain instruction passes through the fetch and operate states; a
// divide then waits in the divide-wait state until the divider is done, which
// comes early with a zero divisor. No new item is taken while a step runs. The
// result is held in an output register until taken, and the next item may be
// accepted meanwhile.
module swimmer_steering_controller import ssc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    ssc_item_if.sink    item,
    ssc_result_if.source result
);

    localparam int          ONE_I   = 1 << FRAC_BITS;
    localparam logic [30:0] Q_ONE   = 31'(ONE_I);
    localparam logic [30:0] Q_HUND  = 31'((ONE_I + 50) / 100);
    localparam logic [30:0] Q_TENTH = 31'((ONE_I + 5) / 10);

    state_t state_reg, state_next;

    logic [1:0]         mode_reg;
    logic [30:0]        len_reg, per_reg, dt_reg;
    logic signed [31:0] ox_reg, oy_reg, oh_reg;

    logic signed [31:0] prev_reg, avh_reg, avy_reg, avw_reg, hcur_reg, hrate_reg;
    logic signed [31:0] lct_reg, sstart_reg, sphase_reg, cper_reg, cprate_reg;
    logic               pflag_reg;
    logic               sat_reg;

    in_item_t           in_reg;
    pc_t                pc_reg;
    instr_t             instr_reg;
    instr_t             fetch;
    logic signed [31:0] rd_a_reg, rd_b_reg;
    logic signed [31:0] tmp_mem [TMP_DEPTH];
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic signed [31:0] opa, opb;
    alu_res_t           alu_res;
    div_req_t           div_req;
    div_res_t           div_res;

    logic               accept, alu_wb, div_wb, branch, emit_load, done_pos;
    logic               take;
    logic               wb_en;
    logic signed [31:0] wb_data;
    logic               wb_sat;

    function automatic logic signed [31:0] operand(input src_t code,
                                                   input logic signed [31:0] mem);
        logic signed [31:0] v;
        if (code[5])
        begin
            v = mem;
        end
        else
        begin
            unique case (code)
                SRC_ZERO:   v = 32'sd0;
                SRC_ONE:    v = {1'b0, Q_ONE};
                SRC_HUND:   v = {1'b0, Q_HUND};
                SRC_TENTH:  v = {1'b0, Q_TENTH};
                SRC_PX:     v = in_reg.pos_x;
                SRC_PY:     v = in_reg.pos_y;
                SRC_HD:     v = in_reg.heading;
                SRC_VX:     v = in_reg.vel_x;
                SRC_VY:     v = in_reg.vel_y;
                SRC_WZ:     v = in_reg.yaw_rate;
                SRC_FX:     v = in_reg.flow_x;
                SRC_FY:     v = in_reg.flow_y;
                SRC_NOW:    v = in_reg.step_time;
                SRC_OX:     v = ox_reg;
                SRC_OY:     v = oy_reg;
                SRC_OH:     v = oh_reg;
                SRC_LEN:    v = {1'b0, len_reg};
                SRC_PER:    v = {1'b0, per_reg};
                SRC_DT:     v = {1'b0, dt_reg};
                SRC_PREV:   v = prev_reg;
                SRC_AVH:    v = avh_reg;
                SRC_AVY:    v = avy_reg;
                SRC_AVW:    v = avw_reg;
                SRC_HCUR:   v = hcur_reg;
                SRC_HRATE:  v = hrate_reg;
                SRC_LCT:    v = lct_reg;
                SRC_SSTART: v = sstart_reg;
                SRC_SPHASE: v = sphase_reg;
                SRC_CPER:   v = cper_reg;
                SRC_CPRATE: v = cprate_reg;
                default:    v = 32'sd0;
            endcase
        end
        return v;
    endfunction

    assign fetch = prog(pc_reg);
    assign opa   = operand(instr_reg.a, rd_a_reg);
    assign opb   = operand(instr_reg.b, rd_b_reg);

    ssc_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .op  (instr_reg.op),
        .a   (opa),
        .b   (opb),
        .res (alu_res)
    );

    ssc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_comb
    begin
        case (instr_reg.op)
            OP_BNOPP:   take = !((opa < 0 && opb > 0) || (opa > 0 && opb < 0));
            OP_BNALIKE: take = !((opa < 0 && opb < 0) || (opa > 0 && opb > 0));
            OP_BNPOS:   take = !(mode_reg == MODE_POS && dt_reg != '0);
            OP_BNTRAJ:  take = !(mode_reg == MODE_TRAJ && dt_reg != '0);
            default:    take = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_OPER;
            end
            ST_OPER:
            begin
                case (instr_reg.op) inside
                    OP_DIV:            state_next = ST_DIVW;
                    OP_DONE, OP_DONEP: state_next = ST_EMIT;
                    default:           state_next = ST_FETCH;
                endcase
            end
            ST_DIVW:
            begin
                if (div_res.done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item.ready    = (state_reg == ST_IDLE);
        accept        = (state_reg == ST_IDLE) && item.valid;
        alu_wb        = 1'b0;
        branch        = 1'b0;
        done_pos      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = opa;
        div_req.den   = opb;
        div_wb        = (state_reg == ST_DIVW) && div_res.done;
        emit_load     = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);
        if (state_reg == ST_OPER)
        begin
            case (instr_reg.op) inside
                OP_ADD, OP_SUB, OP_NEG, OP_ABS, OP_X10, OP_MUL, OP_AVG, OP_SELN:
                    alu_wb = 1'b1;
                OP_DIV:
                    div_req.start = 1'b1;
                OP_BNOPP, OP_BNALIKE, OP_BNPOS, OP_BNTRAJ:
                    branch = 1'b1;
                OP_DONEP:
                    done_pos = 1'b1;
                default:
                    alu_wb = 1'b0;
            endcase
        end
    end

    assign wb_en   = alu_wb || div_wb;
    assign wb_data = alu_wb ? alu_res.value : div_res.value;
    assign wb_sat  = alu_wb ? alu_res.sat : div_res.sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH)
        begin
            rd_a_reg <= tmp_mem[fetch.a[TMP_AW-1:0]];
            rd_b_reg <= tmp_mem[fetch.b[TMP_AW-1:0]];
        end
        if (wb_en && instr_reg.dst[5])
        begin
            tmp_mem[instr_reg.dst[TMP_AW-1:0]] <= wb_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item.data;
        end
        if (state_reg == ST_FETCH)
        begin
            instr_reg <= fetch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pc_reg  <= '0;
                sat_reg <= 1'b0;
            end
            else
            begin
                if (wb_en)
                begin
                    pc_reg <= pc_reg + 1'b1;
                end
                else if (branch)
                begin
                    pc_reg <= take ? instr_reg.tgt : pc_reg + 1'b1;
                end
                if (wb_en && wb_sat)
                begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            len_reg    <= Q_ONE;
            per_reg    <= Q_ONE;
            dt_reg     <= Q_HUND;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oh_reg     <= '0;
            prev_reg   <= '0;
            avh_reg    <= '0;
            avy_reg    <= '0;
            avw_reg    <= '0;
            hcur_reg   <= '0;
            hrate_reg  <= '0;
            lct_reg    <= '0;
            sstart_reg <= '0;
            sphase_reg <= '0;
            cper_reg   <= {1'b0, Q_ONE};
            cprate_reg <= '0;
            pflag_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MODE:   mode_reg <= cfg_data[1:0];
                    CFG_LENGTH: len_reg  <= cfg_data[30:0];
                    CFG_PERIOD:
                    begin
                        per_reg <= cfg_data[30:0];
                        if (!pflag_reg)
                        begin
                            cper_reg <= {1'b0, cfg_data[30:0]};
                        end
                    end
                    CFG_STEP:           dt_reg <= cfg_data[30:0];
                    CFG_ORIGIN_X:       ox_reg <= cfg_data;
                    CFG_ORIGIN_Y:       oy_reg <= cfg_data;
                    CFG_ORIGIN_HEADING: oh_reg <= cfg_data;
                    default:            mode_reg <= mode_reg;
                endcase
            end
            if (wb_en && !instr_reg.dst[5])
            begin
                case (instr_reg.dst)
                    SRC_PREV:   prev_reg   <= wb_data;
                    SRC_AVH:    avh_reg    <= wb_data;
                    SRC_AVY:    avy_reg    <= wb_data;
                    SRC_AVW:    avw_reg    <= wb_data;
                    SRC_HCUR:   hcur_reg   <= wb_data;
                    SRC_HRATE:  hrate_reg  <= wb_data;
                    SRC_LCT:    lct_reg    <= wb_data;
                    SRC_SSTART: sstart_reg <= wb_data;
                    SRC_SPHASE: sphase_reg <= wb_data;
                    SRC_CPER:   cper_reg   <= wb_data;
                    SRC_CPRATE: cprate_reg <= wb_data;
                    default:    prev_reg   <= prev_reg;
                endcase
            end
            if (done_pos)
            begin
                pflag_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_reg.curvature_offset <= hcur_reg;
            out_reg.curvature_rate   <= hrate_reg;
            out_reg.period_value     <= cper_reg;
            out_reg.period_rate      <= cprate_reg;
            out_reg.phase_origin     <= sstart_reg;
            out_reg.phase_shift      <= sphase_reg;
            out_reg.period_active    <= pflag_reg;
            out_reg.saturated        <= sat_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

>>> sim/ssc_steering_checker.sv
`timescale 1ns / 1ps

module ssc_steering_checker import ssc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    ssc_item_if         item,
    ssc_result_if       result,
    output int          errors,
    output int          pending
);

    localparam int QF = FRAC_BITS_DEFAULT;
    localparam int Q_UNIT = 1 << QF;
    localparam int Q_HUNDREDTH = (Q_UNIT + 50) / 100;
    localparam int Q_TENTH = (Q_UNIT + 5) / 10;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    logic [1:0] mode;
    int len, per, dt, ox, oy, oh;
    int prev_wz, avg_hd, avg_lat, avg_wz, curv, curv_rate, last_ctl;
    int seg_start, seg_phase, cur_per, cur_per_rate;
    bit per_flag;
    bit sat_hit;
    out_item_t steer_q[$];

    function automatic int clip(longint v);
        if (v > I32_MAX) begin
            sat_hit = 1;
            return int'(I32_MAX);
        end
        if (v < I32_MIN) begin
            sat_hit = 1;
            return int'(I32_MIN);
        end
        return int'(v);
    endfunction

    function automatic int q_add(int a, int b);
        return clip(longint'(a) + longint'(b));
    endfunction

    function automatic int q_sub(int a, int b);
        return clip(longint'(a) - longint'(b));
    endfunction

    function automatic int q_neg(int a);
        return clip(-longint'(a));
    endfunction

    function automatic int q_abs(int a);
        return a < 0 ? q_neg(a) : a;
    endfunction

    function automatic int q_x10(int a);
        return clip(longint'(a) * 64'sd10);
    endfunction

    function automatic int q_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        if (p >= 0)
            return clip(p >>> QF);
        return clip(-((-p + longint'(Q_UNIT - 1)) >>> QF));
    endfunction

    function automatic int q_div(int a, int b);
        if (b == 0) begin
            sat_hit = 1;
            return a > 0 ? int'(I32_MAX) : (a < 0 ? int'(I32_MIN) : 0);
        end
        return clip((longint'(a) * longint'(Q_UNIT)) / longint'(b));
    endfunction

    function automatic bit opposite(int a, int b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    function automatic bit alike(int a, int b);
        return (a < 0 && b < 0) || (a > 0 && b > 0);
    endfunction

    function automatic out_item_t steer_step(in_item_t d);
        int dtn, xd, yd, ad, ru, rv, mid, avmid, avdiff, vda, vdy, vav;
        int dt10, abs_py, abs_iy, v_py, v_iy, ah, ay, tot, dif, arg;
        int aav, abs_av, abs_avd, term, dinst;
        longint s;
        out_item_t o;
        sat_hit = 0;
        dtn = q_div(dt, per);
        xd = q_div(q_sub(d.pos_x, ox), len);
        yd = q_div(q_sub(d.pos_y, oy), len);
        ad = q_sub(d.heading, oh);
        ru = q_div(q_add(d.vel_x, d.flow_x), len);
        rv = q_div(q_add(d.vel_y, d.flow_y), len);
        s = longint'(d.yaw_rate) + longint'(prev_wz);
        mid = int'((s - ((s < 0) ? 1 : 0)) / 2);
        avmid = q_mul(mid, per);
        avdiff = q_div(q_mul(q_sub(d.yaw_rate, prev_wz), per), dt);
        prev_wz = d.yaw_rate;
        vda = q_add(q_div(q_sub(ad, avg_hd), per), q_mul(dtn, d.yaw_rate));
        vdy = q_add(q_div(q_sub(yd, avg_lat), per), q_mul(dtn, rv));
        vav = q_x10(q_add(q_div(q_sub(avmid, avg_wz), per), q_mul(dtn, avdiff)));
        avg_hd = q_add(q_mul(q_sub(Q_UNIT, dtn), avg_hd), q_mul(dtn, ad));
        avg_lat = q_add(q_mul(q_sub(Q_UNIT, dtn), avg_lat), q_mul(dtn, yd));
        dt10 = q_x10(dtn);
        avg_wz = q_add(q_mul(q_sub(Q_UNIT, dt10), avg_wz), q_mul(dt10, avmid));
        abs_py = q_abs(yd);
        abs_iy = q_abs(avg_lat);
        v_py = yd > 0 ? rv : q_neg(rv);
        v_iy = avg_lat > 0 ? vdy : q_neg(vdy);
        if (mode == MODE_POS && dt != 0) begin
            ah = avg_hd;
            ay = avg_lat;
            tot = 0;
            dif = 0;
            if (opposite(ah, yd)) begin
                tot = q_add(tot, q_mul(ah, abs_py));
                dif = q_add(dif, q_add(q_mul(v_py, ah), q_mul(abs_py, vda)));
            end
            if (opposite(ad, ay)) begin
                tot = q_add(tot, q_mul(ad, abs_iy));
                dif = q_add(dif, q_add(q_mul(v_iy, ad), q_mul(abs_iy, d.yaw_rate)));
            end
            if (opposite(ah, ay)) begin
                tot = q_add(tot, q_mul(ah, abs_iy));
                dif = q_add(dif, q_add(q_mul(v_iy, ah), q_mul(abs_iy, vda)));
            end
            curv = tot;
            curv_rate = dif;
            arg = q_add(q_div(q_sub(last_ctl, seg_start), cur_per), seg_phase);
            seg_start = last_ctl;
            seg_phase = arg;
            cur_per = q_mul(per, q_sub(Q_UNIT, xd));
            cur_per_rate = q_mul(per, q_neg(ru));
            last_ctl = d.step_time;
            per_flag = 1;
        end else if (mode == MODE_TRAJ && dt != 0) begin
            aav = avg_wz;
            abs_av = q_abs(aav);
            abs_avd = aav > 0 ? vav : q_neg(vav);
            term = q_mul(ad, abs_av);
            dinst = q_add(q_mul(ad, abs_avd), q_mul(d.yaw_rate, abs_av));
            if (alike(ad, aav)) begin
                term = q_mul(Q_HUNDREDTH, term);
                dinst = q_mul(Q_HUNDREDTH, dinst);
            end
            curv = q_add(term, q_mul(Q_TENTH, avg_hd));
            curv_rate = q_add(dinst, q_mul(Q_TENTH, vda));
        end
        o.curvature_offset = curv;
        o.curvature_rate = curv_rate;
        o.period_value = cur_per;
        o.period_rate = cur_per_rate;
        o.phase_origin = seg_start;
        o.phase_shift = seg_phase;
        o.period_active = per_flag;
        o.saturated = sat_hit;
        return o;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endtask

    assign pending = steer_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n) begin
            mode = 2'd0;
            len = Q_UNIT;
            per = Q_UNIT;
            dt = Q_HUNDREDTH;
            ox = 0;
            oy = 0;
            oh = 0;
            prev_wz = 0;
            avg_hd = 0;
            avg_lat = 0;
            avg_wz = 0;
            curv = 0;
            curv_rate = 0;
            last_ctl = 0;
            seg_start = 0;
            seg_phase = 0;
            cur_per = per;
            cur_per_rate = 0;
            per_flag = 0;
            errors = 0;
            steer_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE:           mode = cfg_data[1:0];
                    CFG_LENGTH:         len = {1'b0, cfg_data[30:0]};
                    CFG_PERIOD:
                    begin
                        per = {1'b0, cfg_data[30:0]};
                        if (!per_flag)
                            cur_per = per;
                    end
                    CFG_STEP:           dt = {1'b0, cfg_data[30:0]};
                    CFG_ORIGIN_X:       ox = cfg_data;
                    CFG_ORIGIN_Y:       oy = cfg_data;
                    CFG_ORIGIN_HEADING: oh = cfg_data;
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                steer_q.push_back(steer_step(item.data));
            if (result.valid && result.ready) begin
                got = result.data;
                if (steer_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = steer_q.pop_front();
                    check_field("curvature_offset", want.curvature_offset,
                                got.curvature_offset);
                    check_field("curvature_rate", want.curvature_rate, got.curvature_rate);
                    check_field("period_value", want.period_value, got.period_value);
                    check_field("period_rate", want.period_rate, got.period_rate);
                    check_field("phase_origin", want.phase_origin, got.phase_origin);
                    check_field("phase_shift", want.phase_shift, got.phase_shift);
                    check_field("period_active", want.period_active, got.period_active);
                    check_field("saturated", want.saturated, got.saturated);
                end
            end
        end
    end

endmodule

>>> sim/swimmer_steering_controller_tb.sv
`timescale 1ns / 1ps

module swimmer_steering_controller_tb;
    import ssc_pkg::*;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int Q_UNIT = 1 << FRAC_BITS_DEFAULT;
    localparam int RAND_PHASES = 13;
    localparam int PHASE_ITEMS = 150;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    int errors;
    int pending;
    bit src_quiet;
    bit sink_quiet = 0;
    int stall = 0;
    int sink_beats = 0;

    ssc_item_if item ();
    ssc_result_if result ();

    swimmer_steering_controller dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item(item.sink),
        .result(result.source)
    );

    ssc_steering_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item(item),
        .result(result),
        .errors(errors),
        .pending(pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always
    begin
        @(posedge clk);
        if (result.valid && result.ready) begin
            sink_beats++;
            if (sink_beats % 200 == 0)
                sink_quiet = ($urandom_range(0, 3) == 0);
            stall = sink_quiet ? 0 : $urandom_range(0, 14);
        end
        @(negedge clk);
        if (!rst_n) begin
            result.ready <= 1'b0;
        end else if (stall > 0) begin
            result.ready <= 1'b0;
            stall--;
        end else begin
            result.ready <= 1'b1;
        end
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'(Q_UNIT);
                endcase
            end
            1, 2: return $urandom;
            default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'd1;
            2: return $urandom & 32'h7FFF_FFFF;
            default: return 32'($urandom_range(Q_UNIT / 4, Q_UNIT * 4));
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_all(logic [1:0] mode, logic [31:0] len, logic [31:0] per,
                           logic [31:0] step, logic [31:0] x0, logic [31:0] y0,
                           logic [31:0] h0);
        item.valid <= 1'b0;
        settle();
        write_reg(CFG_MODE, {30'd0, mode});
        write_reg(CFG_LENGTH, len);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_STEP, step);
        write_reg(CFG_ORIGIN_X, x0);
        write_reg(CFG_ORIGIN_Y, y0);
        write_reg(CFG_ORIGIN_HEADING, h0);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_beat(in_item_t d);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            item.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.valid <= 1'b1;
        item.data <= d;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_item_t fill(logic [31:0] v);
        in_item_t d;
        d.pos_x = v;
        d.pos_y = v;
        d.heading = v;
        d.vel_x = v;
        d.vel_y = v;
        d.yaw_rate = v;
        d.flow_x = v;
        d.flow_y = v;
        d.step_time = v;
        return d;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t d;
        d.pos_x = rand_q();
        d.pos_y = rand_q();
        d.heading = rand_q();
        d.vel_x = rand_q();
        d.vel_y = rand_q();
        d.yaw_rate = rand_q();
        d.flow_x = rand_q();
        d.flow_y = rand_q();
        d.step_time = rand_q();
        return d;
    endfunction

    task automatic send_extremes();
        send_beat(fill(32'h0));
        send_beat(fill(32'h7FFF_FFFF));
        send_beat(fill(32'h8000_0000));
        send_beat(fill(32'hFFFF_FFFF));
        send_beat(fill(32'(Q_UNIT)));
    endtask

    initial
    begin
        logic [1:0] mode;
        logic [31:0] step;
        item.valid = 1'b0;
        item.data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_quiet = 0;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // tail period loaded before any control, then position mode at extremes
        set_all(MODE_POS, 32'(Q_UNIT), 32'(2 * Q_UNIT), 32'd655, 32'h0, 32'h0, 32'h0);
        send_extremes();
        repeat (3) send_beat(rand_item());
        set_all(MODE_TRAJ, 32'(Q_UNIT), 32'(Q_UNIT), 32'd655, 32'(Q_UNIT), 32'hFFFF_0000,
                32'h0001_8000);
        send_extremes();
        repeat (3) send_beat(rand_item());
        set_all(MODE_OFF, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(rand_item());
        set_all(MODE_SPARE, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h0, 32'h0, 32'h0);
        send_beat(rand_item());
        // zero step, zero length and zero period drive the divide-by-zero paths
        set_all(MODE_POS, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(rand_item());
        set_all(MODE_TRAJ, 32'h0, 32'(Q_UNIT), 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(rand_item());
        set_all(MODE_POS, 32'h8000_0000, 32'h8000_0000, 32'd655, 32'h0, 32'h0, 32'h0);
        send_beat(rand_item());

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0: mode = MODE_OFF;
                1: mode = MODE_SPARE;
                2, 3, 4: mode = MODE_TRAJ;
                default: mode = MODE_POS;
            endcase
            step = ($urandom_range(0, 7) == 0) ? rand_scale() : 32'($urandom_range(0, 8192));
            set_all(mode, rand_scale(), rand_scale(), step, rand_q(), rand_q(), rand_q());
            src_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_beat(rand_item());
            src_quiet = 0;
        end
        item.valid <= 1'b0;
        settle();
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
